FILE: src/assert_macros.svh
// Assertion macros; they expand to nothing in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define PSP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication failed");
`else
`define PSP_ASSERT(lbl, clk, rstn, prop)
`define PSP_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: src/psp_pkg.sv
package psp_pkg;

    localparam int SLOTS_DEF = 1024;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 10;
    localparam int COUNT_W  = 11;
    localparam int TIME_W   = 32;
    localparam int DT_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACTIVE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_LIFE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PER_SLOT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_LIFE   = 2'd3;

    localparam logic [COUNT_W-1:0] MAX_ACTIVE_RST  = 11'd1024;
    localparam logic [TIME_W-1:0]  GLOBAL_LIFE_RST = 32'h0001_0000;
    localparam logic [TIME_W-1:0]  TIME_ENDLESS    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [COUNT_W-1:0] max_active;
        logic [TIME_W-1:0]  global_lifespan;
        logic               per_slot_lifespan;
        logic [TIME_W-1:0]  emitter_lifetime;
    } psp_cfg_t;

    // one strobe per datapath step
    typedef struct packed {
        logic clr_step;
        logic latch;
        logic set_full;
        logic pop;
        logic id_from_count;
        logic take_id;
        logic rd_live_id;
        logic alloc_chk;
        logic set_bad;
        logic rd_live_sid;
        logic free_chk;
        logic tick_start;
        logic walk_rd;
        logic walk_ev;
        logic scan1_init;
        logic scan1_rd;
        logic scan1_ev;
        logic scan1_end;
        logic scan2_init;
        logic scan2_rd;
        logic scan2_ev;
        logic scan2_end;
        logic fin;
    } psp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic full;
        logic stack_nonempty;
        logic sid_bad;
        logic live_q;
        logic walk_more;
        logic count_zero;
        logic rescan_first;
        logic rescan_last;
        logic i_at_end;
        logic i_zero;
    } psp_stat_t;

endpackage

FILE: src/psp_ctrl.sv
module psp_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  logic [psp_pkg::CMD_W-1:0]    in_cmd,
    output logic                         in_ready,
    input  logic                         out_free,
    output logic                         out_load,
    output psp_pkg::psp_cmd_t            cmd,
    input  psp_pkg::psp_stat_t           stat
);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_A0   = 5'd2;
    localparam logic [4:0] S_A1   = 5'd3;
    localparam logic [4:0] S_A2   = 5'd4;
    localparam logic [4:0] S_A3   = 5'd5;
    localparam logic [4:0] S_F0   = 5'd6;
    localparam logic [4:0] S_F1   = 5'd7;
    localparam logic [4:0] S_T0   = 5'd8;
    localparam logic [4:0] S_T1   = 5'd9;
    localparam logic [4:0] S_T2   = 5'd10;
    localparam logic [4:0] S_T3   = 5'd11;
    localparam logic [4:0] S_R1A  = 5'd12;
    localparam logic [4:0] S_R1B  = 5'd13;
    localparam logic [4:0] S_T4   = 5'd14;
    localparam logic [4:0] S_R2A  = 5'd15;
    localparam logic [4:0] S_R2B  = 5'd16;
    localparam logic [4:0] S_FIN  = 5'd17;
    localparam logic [4:0] S_OUT  = 5'd18;

    logic [4:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        out_load   = 1'b0;
        case (state_reg)
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (in_valid) begin
                    cmd.latch = 1'b1;
                    case (in_cmd)
                        psp_pkg::CMD_ALLOC: state_next = S_A0;
                        psp_pkg::CMD_FREE:  state_next = S_F0;
                        psp_pkg::CMD_TICK:  state_next = S_T0;
                        default:            state_next = S_OUT;
                    endcase
                end
            end
            S_A0: begin
                if (stat.full) begin
                    cmd.set_full = 1'b1;
                    state_next   = S_OUT;
                end else if (stat.stack_nonempty) begin
                    cmd.pop    = 1'b1;
                    state_next = S_A1;
                end else begin
                    cmd.id_from_count = 1'b1;
                    state_next        = S_A2;
                end
            end
            S_A1: begin
                cmd.take_id = 1'b1;
                state_next  = S_A2;
            end
            S_A2: begin
                cmd.rd_live_id = 1'b1;
                state_next     = S_A3;
            end
            S_A3: begin
                cmd.alloc_chk = 1'b1;
                state_next    = S_OUT;
            end
            S_F0: begin
                if (stat.sid_bad) begin
                    cmd.set_bad = 1'b1;
                    state_next  = S_OUT;
                end else begin
                    cmd.rd_live_sid = 1'b1;
                    state_next      = S_F1;
                end
            end
            S_F1: begin
                cmd.free_chk = 1'b1;
                state_next   = S_OUT;
            end
            S_T0: begin
                cmd.tick_start = 1'b1;
                state_next     = stat.count_zero ? S_FIN : S_T1;
            end
            S_T1: begin
                cmd.walk_rd = 1'b1;
                state_next  = S_T2;
            end
            S_T2: begin
                cmd.walk_ev = 1'b1;
                state_next  = stat.walk_more ? S_T1 : S_T3;
            end
            S_T3: begin
                if (stat.count_zero) begin
                    state_next = S_FIN;
                end else if (stat.rescan_first) begin
                    cmd.scan1_init = 1'b1;
                    state_next     = S_R1A;
                end else begin
                    state_next = S_T4;
                end
            end
            S_R1A: begin
                if (stat.i_at_end) begin
                    cmd.scan1_end = 1'b1;
                    state_next    = S_T4;
                end else begin
                    cmd.scan1_rd = 1'b1;
                    state_next   = S_R1B;
                end
            end
            S_R1B: begin
                cmd.scan1_ev = 1'b1;
                state_next   = stat.live_q ? S_T4 : S_R1A;
            end
            S_T4: begin
                if (stat.rescan_last) begin
                    cmd.scan2_init = 1'b1;
                    state_next     = S_R2A;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_R2A: begin
                if (stat.i_zero) begin
                    cmd.scan2_end = 1'b1;
                    state_next    = S_FIN;
                end else begin
                    cmd.scan2_rd = 1'b1;
                    state_next   = S_R2B;
                end
            end
            S_R2B: begin
                cmd.scan2_ev = 1'b1;
                state_next   = stat.live_q ? S_FIN : S_R2A;
            end
            S_FIN: begin
                cmd.fin    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/psp_dp.sv
`include "assert_macros.svh"

module psp_dp #(
    parameter int SLOTS = psp_pkg::SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  psp_pkg::psp_cfg_t              cfg,
    input  logic [psp_pkg::SLOT_W-1:0]     in_slot_id,
    input  logic [psp_pkg::TIME_W-1:0]     in_lifespan,
    input  logic [psp_pkg::DT_W-1:0]       in_elapsed,
    input  psp_pkg::psp_cmd_t              cmd,
    output psp_pkg::psp_stat_t             stat,
    output logic [psp_pkg::STATUS_W-1:0]   res_status,
    output logic [psp_pkg::SLOT_W-1:0]     res_granted,
    output logic [psp_pkg::COUNT_W-1:0]    res_live_count,
    output logic [psp_pkg::SLOT_W-1:0]     res_first,
    output logic [psp_pkg::SLOT_W-1:0]     res_last,
    output logic                           res_finished
);

    localparam int ID_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IW    = ID_W + 1;
    localparam int TW    = psp_pkg::TIME_W;

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                              input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    // memories
    logic          live_mem  [SLOTS];
    logic [ID_W-1:0] stk_mem [SLOTS];
    logic [TW-1:0] age_mem   [SLOTS];
    logic [TW-1:0] life_mem  [SLOTS];

    logic            live_q;
    logic [ID_W-1:0] stk_q;
    logic [TW-1:0]   age_q, life_q;

    // state
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] top_reg, top_next;
    logic [ID_W-1:0]  first_reg, first_next;
    logic [ID_W-1:0]  last_reg, last_next;
    logic             rf_reg, rf_next;
    logic             rl_reg, rl_next;
    logic [TW-1:0]    eage_reg, eage_next;
    logic [IW-1:0]    i_reg, i_next;
    logic [ID_W-1:0]  hi_reg, hi_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [ID_W-1:0]  sid_reg, sid_next;
    logic             sid_bad_reg, sid_bad_next;
    logic [TW-1:0]    life_reg, life_next;
    logic [psp_pkg::DT_W-1:0] dt_reg, dt_next;
    logic [psp_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]  granted_reg, granted_next;
    logic             fin_reg, fin_next;

    logic [ID_W-1:0] i_id;
    logic [IW-1:0]   i_inc;
    logic [TW-1:0]   age_sum, lim;
    logic            expire, rel_en, alloc_en;
    logic [ID_W-1:0] rel_id;
    logic [CNT_W-1:0] cnt_after;
    logic            expired;

    logic            live_we, live_wd, live_re;
    logic [ID_W-1:0] live_wa, live_ra;
    logic            stk_we;
    logic            age_we;
    logic [ID_W-1:0] age_wa;
    logic [TW-1:0]   age_wd;

    assign i_id    = i_reg[ID_W-1:0];
    assign i_inc   = i_reg + 1'b1;
    assign age_sum = sat_add(age_q, TW'(dt_reg));
    assign lim     = cfg.per_slot_lifespan ? life_q : cfg.global_lifespan;
    assign expire  = (age_sum >= lim);
    assign rel_en  = (cmd.free_chk && live_q) || (cmd.walk_ev && live_q && expire);
    assign rel_id  = cmd.free_chk ? sid_reg : i_id;
    assign alloc_en = cmd.alloc_chk && !live_q;
    assign cnt_after = rel_en ? count_reg - 1'b1 : count_reg;
    assign expired = (cfg.emitter_lifetime != psp_pkg::TIME_ENDLESS)
                     && (eage_reg >= cfg.emitter_lifetime);

    always_comb begin
        stat                = '0;
        stat.clr_last       = (i_reg == IW'(SLOTS - 1));
        stat.full           = (32'(count_reg) >= 32'(cfg.max_active))
                              || (32'(count_reg) >= SLOTS);
        stat.stack_nonempty = (top_reg != '0);
        stat.sid_bad        = sid_bad_reg;
        stat.live_q         = live_q;
        stat.walk_more      = (i_inc <= {1'b0, hi_reg}) && (cnt_after != '0);
        stat.count_zero     = (count_reg == '0);
        stat.rescan_first   = rf_reg;
        stat.rescan_last    = rl_reg;
        stat.i_at_end       = (i_reg >= IW'(SLOTS));
        stat.i_zero         = (i_reg == '0);
    end

    // memory port selection
    always_comb begin
        live_we = 1'b0;
        live_wa = i_id;
        live_wd = 1'b0;
        if (cmd.clr_step) begin
            live_we = 1'b1;
        end else if (alloc_en) begin
            live_we = 1'b1;
            live_wa = id_reg;
            live_wd = 1'b1;
        end else if (rel_en) begin
            live_we = 1'b1;
            live_wa = rel_id;
        end
        live_re = cmd.rd_live_id || cmd.rd_live_sid || cmd.walk_rd
                  || cmd.scan1_rd || cmd.scan2_rd;
        if (cmd.rd_live_id) begin
            live_ra = id_reg;
        end else if (cmd.rd_live_sid) begin
            live_ra = sid_reg;
        end else if (cmd.scan2_rd) begin
            live_ra = ID_W'(i_reg - 1'b1);
        end else begin
            live_ra = i_id;
        end
        stk_we = rel_en && (32'(top_reg) < SLOTS);
        age_we = alloc_en || (cmd.walk_ev && live_q);
        age_wa = alloc_en ? id_reg : i_id;
        age_wd = alloc_en ? '0 : age_sum;
    end

    always_ff @(posedge aclk) begin
        if (live_we) live_mem[live_wa] <= live_wd;
        if (live_re) live_q <= live_mem[live_ra];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) stk_mem[ID_W'(top_reg)] <= rel_id;
        if (cmd.pop) stk_q <= stk_mem[ID_W'(top_reg - 1'b1)];
    end

    always_ff @(posedge aclk) begin
        if (age_we) age_mem[age_wa] <= age_wd;
        if (alloc_en) life_mem[id_reg] <= life_reg;
        if (cmd.walk_rd) begin
            age_q  <= age_mem[i_id];
            life_q <= life_mem[i_id];
        end
    end

    always_comb begin
        count_next   = count_reg;
        top_next     = top_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        rf_next      = rf_reg;
        rl_next      = rl_reg;
        eage_next    = eage_reg;
        i_next       = i_reg;
        hi_next      = hi_reg;
        id_next      = id_reg;
        sid_next     = sid_reg;
        sid_bad_next = sid_bad_reg;
        life_next    = life_reg;
        dt_next      = dt_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        fin_next     = fin_reg;

        if (cmd.clr_step) i_next = i_inc;
        if (cmd.latch) begin
            sid_next     = ID_W'(in_slot_id);
            sid_bad_next = (32'(in_slot_id) >= SLOTS);
            life_next    = in_lifespan;
            dt_next      = in_elapsed;
            status_next  = psp_pkg::STATUS_OK;
            granted_next = '0;
            fin_next     = 1'b0;
        end
        if (cmd.set_full) status_next = psp_pkg::STATUS_FULL;
        if (cmd.set_bad)  status_next = psp_pkg::STATUS_BAD_FREE;
        if (cmd.pop)      top_next = top_reg - 1'b1;
        if (cmd.id_from_count) id_next = ID_W'(count_reg);
        if (cmd.take_id)  id_next = stk_q;
        if (cmd.alloc_chk) begin
            if (alloc_en) begin
                count_next   = count_reg + 1'b1;
                granted_next = id_reg;
                if (count_reg == '0) begin
                    first_next = id_reg;
                    last_next  = id_reg;
                    rf_next    = 1'b0;
                    rl_next    = 1'b0;
                end else if (id_reg <= first_reg) begin
                    first_next = id_reg;
                    rf_next    = 1'b0;
                end else if (id_reg >= last_reg) begin
                    last_next = id_reg;
                    rl_next   = 1'b0;
                end
            end else begin
                status_next = psp_pkg::STATUS_FULL;
            end
        end
        if (cmd.free_chk && !live_q) status_next = psp_pkg::STATUS_BAD_FREE;
        if (cmd.tick_start) begin
            eage_next = sat_add(eage_reg, TW'(dt_reg));
            i_next    = {1'b0, first_reg};
            hi_next   = last_reg;
        end
        if (cmd.walk_ev) i_next = i_inc;
        if (rel_en) begin
            count_next = cnt_after;
            if (cnt_after == '0) begin
                first_next = '0;
                last_next  = '0;
                rf_next    = 1'b0;
                rl_next    = 1'b0;
            end else if (rel_id == first_reg) begin
                rf_next = 1'b1;
            end else if (rel_id == last_reg) begin
                rl_next = 1'b1;
            end
            if (stk_we) top_next = top_reg + 1'b1;
        end
        if (cmd.scan1_init) i_next = {1'b0, first_reg} + 1'b1;
        if (cmd.scan1_end)  rf_next = 1'b0;
        if (cmd.scan1_ev) begin
            if (live_q) begin
                first_next = i_id;
                rf_next    = 1'b0;
            end else begin
                i_next = i_inc;
            end
        end
        if (cmd.scan2_init) i_next = {1'b0, last_reg};
        if (cmd.scan2_end)  rl_next = 1'b0;
        if (cmd.scan2_ev) begin
            if (live_q) begin
                last_next = ID_W'(i_reg - 1'b1);
                rl_next   = 1'b0;
            end else begin
                i_next = i_reg - 1'b1;
            end
        end
        if (cmd.fin) fin_next = expired && (count_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            top_reg   <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            rf_reg    <= 1'b0;
            rl_reg    <= 1'b0;
            eage_reg  <= '0;
            i_reg     <= '0;
        end else begin
            count_reg <= count_next;
            top_reg   <= top_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            rf_reg    <= rf_next;
            rl_reg    <= rl_next;
            eage_reg  <= eage_next;
            i_reg     <= i_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg      <= hi_next;
        id_reg      <= id_next;
        sid_reg     <= sid_next;
        sid_bad_reg <= sid_bad_next;
        life_reg    <= life_next;
        dt_reg      <= dt_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        fin_reg     <= fin_next;
    end

    assign res_status     = status_reg;
    assign res_granted    = psp_pkg::SLOT_W'(granted_reg);
    assign res_live_count = psp_pkg::COUNT_W'(count_reg);
    assign res_first      = psp_pkg::SLOT_W'(first_reg);
    assign res_last       = psp_pkg::SLOT_W'(last_reg);
    assign res_finished   = fin_reg;

    `PSP_ASSERT(a_count_range, aclk, aresetn, 32'(count_reg) <= SLOTS)
    `PSP_ASSERT(a_top_range, aclk, aresetn, 32'(top_reg) <= SLOTS)
    `PSP_ASSERT_IMPL(a_empty_ends, aclk, aresetn, count_reg == '0, first_reg == '0 && last_reg == '0 && !rf_reg && !rl_reg)
    `PSP_ASSERT(a_one_live_write, aclk, aresetn, !(alloc_en && rel_en))

endmodule

FILE: src/particle_slot_pool_with_aging.sv
// Channel   Direction  Handshake                  Content
// s_        in         s_tvalid / s_tready        one command item
// m_        out        m_tvalid / m_tready        one result item per command
// cfg_      in         cfg_valid / cfg_ready      register index and write data
//
// Allocate, free, tick and an unknown command each end by loading the result into the
// output register. A tick visits each slot from the first to the last live slot, and
// each end rescan steps slot by slot: the live map has one read port, one slot per
// visit.
// After reset a clearing pass zeroes the live map; no item is taken meanwhile. A held
// result stalls the next result and also acceptance of the next item.
module particle_slot_pool_with_aging #(
    parameter int SLOTS = psp_pkg::SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // slot_id [9:0], new_lifespan [41:10], elapsed [65:42], zero pad
    input  logic [71:0]                     s_tdata,
    // cmd [1:0]
    input  logic [psp_pkg::CMD_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // granted_slot [9:0], live_count [20:10], first_live [30:21],
    // last_live [40:31], finished [41], zero pad
    output logic [47:0]                     m_tdata,
    // status [1:0]
    output logic [psp_pkg::STATUS_W-1:0]    m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [psp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);

    psp_pkg::psp_cfg_t  cfg_reg;
    psp_pkg::psp_cmd_t  cmd;
    psp_pkg::psp_stat_t stat;

    logic                             out_load, out_free;
    logic                             m_tvalid_reg;
    logic [47:0]                      m_tdata_reg;
    logic [psp_pkg::STATUS_W-1:0]     m_tuser_reg;
    logic [psp_pkg::STATUS_W-1:0]     res_status;
    logic [psp_pkg::SLOT_W-1:0]       res_granted, res_first, res_last;
    logic [psp_pkg::COUNT_W-1:0]      res_live_count;
    logic                             res_finished;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_active        <= psp_pkg::MAX_ACTIVE_RST;
            cfg_reg.global_lifespan   <= psp_pkg::GLOBAL_LIFE_RST;
            cfg_reg.per_slot_lifespan <= 1'b1;
            cfg_reg.emitter_lifetime  <= psp_pkg::TIME_ENDLESS;
        end else if (cfg_valid) begin
            case (cfg_index)
                psp_pkg::CFG_MAX_ACTIVE:
                    cfg_reg.max_active <= cfg_data[psp_pkg::COUNT_W-1:0];
                psp_pkg::CFG_GLOBAL_LIFE:
                    cfg_reg.global_lifespan <= cfg_data;
                psp_pkg::CFG_PER_SLOT:
                    cfg_reg.per_slot_lifespan <= cfg_data[0];
                psp_pkg::CFG_EMIT_LIFE:
                    cfg_reg.emitter_lifetime <= cfg_data;
                default: ;
            endcase
        end
    end

    psp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .cmd      (cmd),
        .stat     (stat)
    );

    psp_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_slot_id     (s_tdata[9:0]),
        .in_lifespan    (s_tdata[41:10]),
        .in_elapsed     (s_tdata[65:42]),
        .cmd            (cmd),
        .stat           (stat),
        .res_status     (res_status),
        .res_granted    (res_granted),
        .res_live_count (res_live_count),
        .res_first      (res_first),
        .res_last       (res_last),
        .res_finished   (res_finished)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {6'b0, res_finished, res_last, res_first,
                            res_live_count, res_granted};
            m_tuser_reg <= res_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int NSLOT     = 1024;
    localparam int IDLE_MAX  = 60000;
    localparam int RAND_PHASE = 210;
    localparam logic [psp_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [psp_pkg::STATUS_W-1:0] status;
        logic [psp_pkg::SLOT_W-1:0]   granted;
        logic [psp_pkg::COUNT_W-1:0]  count;
        logic [psp_pkg::SLOT_W-1:0]   first;
        logic [psp_pkg::SLOT_W-1:0]   last;
        logic                         fin;
    } pool_res_t;

    typedef struct {
        logic [psp_pkg::CMD_W-1:0]  cmd;
        logic [psp_pkg::SLOT_W-1:0] sid;
        logic [psp_pkg::TIME_W-1:0] life;
        logic [psp_pkg::DT_W-1:0]   dt;
        bit                         typed;
        pool_res_t                  res;
    } row_t;

    logic aclk, aresetn;
    logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_valid, cfg_ready;
    logic [71:0] s_tdata;
    logic [psp_pkg::CMD_W-1:0] s_tuser;
    logic [47:0] m_tdata;
    logic [psp_pkg::STATUS_W-1:0] m_tuser;
    logic [psp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    particle_slot_pool_with_aging dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // pool shadow
    logic [psp_pkg::COUNT_W-1:0] sh_max_active;
    logic [psp_pkg::TIME_W-1:0]  sh_glob_life, sh_emit_life, sh_emit_age;
    logic                        sh_per_slot;
    logic [psp_pkg::SLOT_W-1:0]  free_lifo [NSLOT];
    int                          lifo_depth, n_live, first_id, last_id;
    bit                          live_bit [NSLOT];
    bit                          fix_first, fix_last;
    logic [psp_pkg::TIME_W-1:0]  age_of [NSLOT], span_of [NSLOT];

    pool_res_t pending [$];
    int n_err, n_results, n_items, n_full, n_bad, n_fin, n_expired;

    always #5 aclk = ~aclk;

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void drop_slot(int id);
        n_live--;
        if (n_live == 0) begin
            first_id = 0; last_id = 0; fix_first = 0; fix_last = 0;
        end else if (id == first_id) begin
            fix_first = 1;
        end else if (id == last_id) begin
            fix_last = 1;
        end
        live_bit[id] = 0;
        if (lifo_depth < NSLOT) begin
            free_lifo[lifo_depth] = psp_pkg::SLOT_W'(id);
            lifo_depth++;
        end
    endfunction

    function automatic pool_res_t pool_step(logic [psp_pkg::CMD_W-1:0] cmd,
                                            logic [psp_pkg::SLOT_W-1:0] sid,
                                            logic [psp_pkg::TIME_W-1:0] life,
                                            logic [psp_pkg::DT_W-1:0] dt);
        pool_res_t r;
        int limit, id, hi;
        bit expired;
        logic [psp_pkg::TIME_W-1:0] lim;
        r = '0;
        case (cmd)
            psp_pkg::CMD_ALLOC: begin
                limit = (sh_max_active > NSLOT) ? NSLOT : sh_max_active;
                if (n_live >= limit) begin
                    r.status = psp_pkg::STATUS_FULL;
                end else begin
                    if (lifo_depth > 0) begin
                        lifo_depth--;
                        id = free_lifo[lifo_depth];
                    end else begin
                        id = n_live;
                    end
                    if (id < NSLOT && !live_bit[id]) begin
                        live_bit[id] = 1;
                        age_of[id] = 0;
                        span_of[id] = life;
                        n_live++;
                        if (n_live == 1) begin
                            first_id = id; last_id = id; fix_first = 0; fix_last = 0;
                        end else if (id <= first_id) begin
                            first_id = id; fix_first = 0;
                        end else if (id >= last_id) begin
                            last_id = id; fix_last = 0;
                        end
                        r.granted = psp_pkg::SLOT_W'(id);
                    end else begin
                        r.status = psp_pkg::STATUS_FULL;
                    end
                end
            end
            psp_pkg::CMD_FREE: begin
                if (!live_bit[sid]) r.status = psp_pkg::STATUS_BAD_FREE;
                else drop_slot(sid);
            end
            psp_pkg::CMD_TICK: begin
                sh_emit_age = add_sat(sh_emit_age, {8'd0, dt});
                expired = (sh_emit_life != psp_pkg::TIME_ENDLESS)
                          && (sh_emit_age >= sh_emit_life);
                if (n_live > 0) begin
                    hi = last_id;
                    for (int i = first_id; i <= hi && i < NSLOT && n_live > 0; i++) begin
                        if (live_bit[i]) begin
                            age_of[i] = add_sat(age_of[i], {8'd0, dt});
                            lim = sh_per_slot ? span_of[i] : sh_glob_life;
                            if (age_of[i] >= lim) begin
                                drop_slot(i);
                                n_expired++;
                            end
                        end
                    end
                    if (n_live > 0) begin
                        if (fix_first) begin
                            for (int i = first_id + 1; i < NSLOT; i++)
                                if (live_bit[i]) begin first_id = i; break; end
                            fix_first = 0;
                        end
                        if (fix_last) begin
                            for (int i = last_id; i > 0; i--)
                                if (live_bit[i-1]) begin last_id = i - 1; break; end
                            fix_last = 0;
                        end
                    end
                end
                r.fin = expired && n_live == 0;
            end
            default: ;
        endcase
        r.count = psp_pkg::COUNT_W'(n_live);
        r.first = psp_pkg::SLOT_W'(first_id);
        r.last  = psp_pkg::SLOT_W'(last_id);
        return r;
    endfunction

    // result check
    always @(posedge aclk) begin
        pool_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[9:0], m_tdata[20:10], m_tdata[30:21], m_tdata[40:31],
                    m_tdata[41]};
            n_results++;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    n_err++;
                    if (n_err <= 10) $display("mismatch: expected %p, got %p", want, got);
                end
                if (want.status == psp_pkg::STATUS_FULL) n_full++;
                if (want.status == psp_pkg::STATUS_BAD_FREE) n_bad++;
                if (want.fin) n_fin++;
            end
        end
    end

    // receiver stall pattern: phases of full readiness and random stalls
    int stall_cnt;
    logic stall_mode;
    always @(negedge aclk) begin
        if (stall_cnt == 0) begin
            stall_cnt = $urandom_range(10, 80);
            stall_mode = $urandom_range(0, 2) != 0;
        end
        stall_cnt--;
        m_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // watchdog
    int quiet;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= IDLE_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(logic [psp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid = 1; cfg_index = idx; cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            psp_pkg::CFG_MAX_ACTIVE:  sh_max_active = val[psp_pkg::COUNT_W-1:0];
            psp_pkg::CFG_GLOBAL_LIFE: sh_glob_life = val;
            psp_pkg::CFG_PER_SLOT:    sh_per_slot = val[0];
            psp_pkg::CFG_EMIT_LIFE:   sh_emit_life = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    int burst_left;
    task automatic push_item(logic [psp_pkg::CMD_W-1:0] cmd,
                             logic [psp_pkg::SLOT_W-1:0] sid,
                             logic [psp_pkg::TIME_W-1:0] life,
                             logic [psp_pkg::DT_W-1:0] dt,
                             bit typed, pool_res_t tres);
        pool_res_t p;
        @(negedge aclk);
        s_tvalid = 1; s_tuser = cmd; s_tdata = {6'd0, dt, life, sid};
        do @(posedge aclk); while (!s_tready);
        p = pool_step(cmd, sid, life, dt);
        pending.push_back(typed ? tres : p);
        n_items++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 8);
            @(negedge aclk);
            s_tvalid = 0;
            repeat ($urandom_range(0, 4)) @(negedge aclk);
        end
    endtask

    // a burst may still hold tvalid high; drop it before waiting
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_items(int n, int life_max, int dt_max);
        logic [psp_pkg::CMD_W-1:0] cmd;
        logic [psp_pkg::SLOT_W-1:0] sid;
        logic [psp_pkg::TIME_W-1:0] life;
        logic [psp_pkg::DT_W-1:0] dt;
        int pick, start;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            cmd = pick < 45 ? psp_pkg::CMD_ALLOC : pick < 72 ? psp_pkg::CMD_FREE :
                  pick < 95 ? psp_pkg::CMD_TICK : CMD_NONE;
            sid = psp_pkg::SLOT_W'($urandom);
            // mostly free a slot that is live
            if (cmd == psp_pkg::CMD_FREE && n_live > 0 && $urandom_range(0, 4) != 0) begin
                start = $urandom_range(0, NSLOT - 1);
                for (int k = 0; k < NSLOT; k++)
                    if (live_bit[(start + k) % NSLOT]) begin
                        sid = psp_pkg::SLOT_W'((start + k) % NSLOT);
                        break;
                    end
            end
            life = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, life_max);
            dt = psp_pkg::DT_W'(($urandom_range(0, 9) == 0) ? $urandom
                                                             : $urandom_range(0, dt_max));
            push_item(cmd, sid, life, dt, 0, '0);
        end
    endtask

    row_t rows [$];
    initial begin
        aclk = 0; aresetn = 0;
        s_tvalid = 0; s_tdata = '0; s_tuser = psp_pkg::CMD_ALLOC;
        cfg_valid = 0; cfg_index = psp_pkg::CFG_MAX_ACTIVE; cfg_data = '0;
        m_tready = 0; stall_cnt = 0; quiet = 0; burst_left = 0;
        n_err = 0; n_results = 0; n_items = 0; n_full = 0; n_bad = 0; n_fin = 0;
        n_expired = 0;
        sh_max_active = psp_pkg::MAX_ACTIVE_RST; sh_glob_life = psp_pkg::GLOBAL_LIFE_RST;
        sh_per_slot = 1; sh_emit_life = psp_pkg::TIME_ENDLESS; sh_emit_age = 0;
        lifo_depth = 0; n_live = 0; first_id = 0; last_id = 0;
        fix_first = 0; fix_last = 0;
        foreach (live_bit[i]) begin
            live_bit[i] = 0; age_of[i] = 0; span_of[i] = 0; free_lifo[i] = 0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed, reset configuration
        rows = '{
            '{psp_pkg::CMD_ALLOC, 10'd0, 32'h0001_0000, 24'd0, 1,
              '{psp_pkg::STATUS_OK, 10'd0, 11'd1, 10'd0, 10'd0, 1'b0}},
            '{psp_pkg::CMD_ALLOC, 10'd0, 32'hFFFF_FFFF, 24'd0, 1,
              '{psp_pkg::STATUS_OK, 10'd1, 11'd2, 10'd0, 10'd1, 1'b0}},
            '{psp_pkg::CMD_ALLOC, 10'd0, 32'd0, 24'd0, 0, '0},
            '{psp_pkg::CMD_FREE, 10'd1023, 32'd0, 24'd0, 1,
              '{psp_pkg::STATUS_BAD_FREE, 10'd0, 11'd3, 10'd0, 10'd2, 1'b0}},
            '{psp_pkg::CMD_FREE, 10'd1, 32'd0, 24'd0, 0, '0},
            '{psp_pkg::CMD_FREE, 10'd1, 32'd0, 24'd0, 0, '0},
            '{CMD_NONE, 10'h3FF, 32'hFFFF_FFFF, 24'hFFFFFF, 0, '0},
            '{psp_pkg::CMD_TICK, 10'd0, 32'd0, 24'd0, 0, '0},
            '{psp_pkg::CMD_ALLOC, 10'h3FF, 32'h0002_0000, 24'hFFFFFF, 0, '0},
            '{psp_pkg::CMD_ALLOC, 10'd0, 32'h0000_8000, 24'd0, 0, '0},
            '{psp_pkg::CMD_FREE, 10'd0, 32'd0, 24'd0, 0, '0},
            '{psp_pkg::CMD_TICK, 10'd0, 32'd0, 24'h00_8000, 0, '0},
            '{psp_pkg::CMD_TICK, 10'd0, 32'd0, 24'hFFFFFF, 0, '0},
            '{psp_pkg::CMD_TICK, 10'd0, 32'd0, 24'hFFFFFF, 0, '0},
            '{psp_pkg::CMD_ALLOC, 10'd0, 32'hFFFF_FFFF, 24'd0, 0, '0},
            '{psp_pkg::CMD_ALLOC, 10'd0, 32'hFFFF_FFFF, 24'd0, 0, '0},
            '{psp_pkg::CMD_FREE, 10'd1023, 32'd0, 24'd0, 0, '0},
            '{psp_pkg::CMD_TICK, 10'd0, 32'd0, 24'd1, 0, '0}
        };
        foreach (rows[i])
            push_item(rows[i].cmd, rows[i].sid, rows[i].life, rows[i].dt,
                      rows[i].typed, rows[i].res);
        drain();

        // pool-full corner: one slot allowed
        write_reg(psp_pkg::CFG_MAX_ACTIVE, 32'd1);
        push_item(psp_pkg::CMD_ALLOC, 10'd0, 32'd5, 24'd0, 0, '0);
        push_item(psp_pkg::CMD_ALLOC, 10'd0, 32'd5, 24'd0, 0, '0);
        random_items(RAND_PHASE, 32'h0008_0000, 32'h0002_0000);
        drain();

        write_reg(psp_pkg::CFG_MAX_ACTIVE, 32'd0);
        write_reg(psp_pkg::CFG_GLOBAL_LIFE, 32'd0);
        write_reg(psp_pkg::CFG_PER_SLOT, 32'd0);
        write_reg(psp_pkg::CFG_EMIT_LIFE, 32'd0);
        random_items(40, 32'h0008_0000, 32'h0002_0000);
        drain();

        write_reg(psp_pkg::CFG_MAX_ACTIVE, 32'd16);
        write_reg(psp_pkg::CFG_GLOBAL_LIFE, 32'h0004_0000);
        random_items(RAND_PHASE, 32'h0008_0000, 32'h0001_0000);
        drain();

        write_reg(psp_pkg::CFG_MAX_ACTIVE, 32'd40);
        write_reg(psp_pkg::CFG_PER_SLOT, 32'd1);
        write_reg(psp_pkg::CFG_EMIT_LIFE, 32'hFFFF_FFFE);
        random_items(RAND_PHASE, 32'h0006_0000, 32'h0001_0000);
        drain();

        write_reg(psp_pkg::CFG_MAX_ACTIVE, 32'd2047);
        write_reg(psp_pkg::CFG_GLOBAL_LIFE, 32'hFFFF_FFFF);
        write_reg(psp_pkg::CFG_EMIT_LIFE, 32'hFFFF_FFFF);
        random_items(RAND_PHASE, 32'h0010_0000, 32'h0002_0000);
        drain();

        write_reg(psp_pkg::CFG_MAX_ACTIVE, 32'd8);
        write_reg(psp_pkg::CFG_PER_SLOT, 32'd0);
        write_reg(psp_pkg::CFG_GLOBAL_LIFE, 32'h0001_0000);
        random_items(RAND_PHASE, 32'h0004_0000, 32'h0000_8000);
        drain();

        $display("items %0d, results %0d: %0d pool full, %0d bad frees, %0d expirations,",
                 n_items, n_results, n_full, n_bad, n_expired);
        $display("%0d finished ticks, over seven register settings", n_fin);
        if (n_err == 0 && pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+src
src/psp_pkg.sv
src/psp_ctrl.sv
src/psp_dp.sv
src/particle_slot_pool_with_aging.sv
verif/testbench.sv
